@@ rtl/core/huffman_tree_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared property wrappers for the decoder core. They sample on clock and
// are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTD_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/htd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Widths, command codes, payload structs and the child selection helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htd_pkg;

   // Node table geometry.
   localparam int NODE_COUNT = 512;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int IDX_W      = 9;
   localparam int ENTRY_W    = 2 * IDX_W;
   localparam int SYM_W      = 8;
   localparam int CNT_W      = 32;

   // Command codes.
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_DECODE  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] node_slot;
      logic [IDX_W-1:0] left_child;
      logic [IDX_W-1:0] right_child;
      logic [7:0]       data_byte;
      logic             last_byte;
   } htd_req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             run_end;
      logic             stream_done;
      logic             truncated;
   } htd_rsp_type;

   // Pick the child for one stream bit; an index beyond the table is the root.
   function automatic logic [NODE_AW-1:0] pick_child(logic [ENTRY_W-1:0] entry,
                                                     logic             bit_val);
      logic [IDX_W-1:0] idx;
      idx = bit_val ? entry[IDX_W-1:0] : entry[ENTRY_W-1:IDX_W];
      if (32'(idx) >= 32'(NODE_COUNT)) begin
         return '0;
      end
      return idx[NODE_AW-1:0];
   endfunction

endpackage

@@ rtl/core/htd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/huffman_tree_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Huffman tree decoder core
// Walks a node table held in RAM, one stream bit per table read.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries commands: load a node into the table, decode one byte
//          (most significant bit first), or restart the stream.
//   rsp_*  carries decoded symbols and the truncation status, one per transfer.
//   csr_*  writes the symbol total; it is always ready and should be written
//          only while the core is idle.
// Load, restart, ignored and swallowed commands leave the core idle. A decode
// byte runs from its transfer cycle through a read that fetches the first child,
// one read per bit (each one dependent read of the node table RAM) and the
// release of the held symbol before the next request transfer; a truncation
// status adds a further step, and reaching the total mid-byte drops the
// remaining bits. Each symbol is held until the next leaf or the end of the
// byte shows whether it closes the byte's results. One byte is worked on at a
// time.
// When the receiver stalls with a result waiting, the walk holds on the next
// leaf until the result register frees, and the request side stays not ready.
// Reset clears the walk, the symbol count, the done flag and the symbol
// total. The node table is not cleared and reads as undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_tree_decoder_core_defines.svh"

module huffman_tree_decoder_core
   import htd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  htd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output htd_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_FLUSH  = 4'b0100,
      ST_STATUS = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [NODE_AW-1:0]   walk_ff, walk_in;
   logic [ENTRY_W-1:0]   cur_ff, cur_in;
   logic [ENTRY_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 finished_ff, finished_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [2:0]           bit_ff, bit_in;
   logic                 pending_ff, pending_in;
   logic [NODE_AW-1:0]   child_ff, child_in;
   logic                 held_valid_ff, held_valid_in;
   htd_rsp_type          held_ff, held_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   htd_rsp_type          rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic                 rsp_free;
   logic                 ram_we;
   logic                 ram_re;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [NODE_AW-1:0]   slot_addr;
   logic                 is_leaf;
   logic [CNT_W-1:0]     count_inc;
   logic                 hit_total;
   logic [ENTRY_W-1:0]   next_cur;
   logic [2:0]           next_bit;
   logic                 need_status;
   logic                 emit;
   htd_rsp_type          emit_data;

   // Node table.
   htd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(slot_addr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(child_in),
      .rd_data(ram_rdata)
   );

   // Handshake and shared terms.
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign csr_ready   = 1'b1;
   assign slot_addr   = req_data.node_slot[NODE_AW-1:0];
   assign ram_wdata   = {req_data.left_child, req_data.right_child};
   assign is_leaf     = (ram_rdata[ENTRY_W-1:IDX_W] == ram_rdata[IDX_W-1:0]);
   assign count_inc   = count_ff + CNT_W'(1);
   assign hit_total   = (count_inc >= total_ff);
   assign next_cur    = is_leaf ? root_ff : ram_rdata;
   assign next_bit    = bit_ff - 3'd1;
   assign need_status = last_ff && !finished_ff;

   // Command decode and the per-bit walk.
   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      count_in      = count_ff;
      finished_in   = finished_ff;
      total_in      = total_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      bit_in        = bit_ff;
      pending_in    = pending_ff;
      child_in      = child_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;

      if (csr_valid && csr_ready) begin
         total_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_data.cmd)
                  CMD_LOAD: begin
                     if (32'(req_data.node_slot) < 32'(NODE_COUNT)) begin
                        ram_we = 1'b1;
                        // Keep the cached current and root nodes coherent.
                        if (slot_addr == walk_ff) begin
                           cur_in = ram_wdata;
                        end
                        if (slot_addr == '0) begin
                           root_in = ram_wdata;
                        end
                     end
                  end
                  CMD_DECODE: begin
                     if (!finished_ff && (count_ff < total_ff)) begin
                        byte_in    = req_data.data_byte;
                        last_in    = req_data.last_byte;
                        bit_in     = 3'd7;
                        pending_in = 1'b0;
                        state_in   = ST_WALK;
                     end
                  end
                  CMD_RESTART: begin
                     walk_in     = '0;
                     cur_in      = root_ff;
                     count_in    = '0;
                     finished_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (!pending_ff) begin
               // Fetch the child for the first bit of the byte.
               child_in   = pick_child(cur_ff, byte_ff[bit_ff]);
               ram_re     = 1'b1;
               pending_in = 1'b1;
            end else if (!(is_leaf && held_valid_ff) || rsp_free) begin
               walk_in = is_leaf ? '0 : child_ff;
               cur_in  = next_cur;
               if (is_leaf) begin
                  // A new leaf shows that the held symbol does not close the byte.
                  emit                = held_valid_ff;
                  emit_data           = held_ff;
                  count_in            = count_inc;
                  held_valid_in       = 1'b1;
                  held_in             = '0;
                  held_in.symbol      = ram_rdata[SYM_W-1:0];
                  held_in.stream_done = hit_total;
               end
               if (is_leaf && hit_total) begin
                  finished_in = 1'b1;
                  pending_in  = 1'b0;
                  state_in    = ST_FLUSH;
               end else if (bit_ff == 3'd0) begin
                  pending_in = 1'b0;
                  state_in   = ST_FLUSH;
               end else begin
                  // Start the read for the next bit from the updated node.
                  bit_in   = next_bit;
                  child_in = pick_child(next_cur, byte_ff[next_bit]);
                  ram_re   = 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            // Release the held symbol; it closes the byte unless a status follows.
            if (!held_valid_ff) begin
               state_in = need_status ? ST_STATUS : ST_IDLE;
            end else if (rsp_free) begin
               emit              = 1'b1;
               emit_data         = held_ff;
               emit_data.run_end = !need_status;
               held_valid_in     = 1'b0;
               state_in          = need_status ? ST_STATUS : ST_IDLE;
            end
         end

         ST_STATUS: begin
            if (rsp_free) begin
               emit                = 1'b1;
               emit_data.run_end   = 1'b1;
               emit_data.truncated = 1'b1;
               finished_in         = 1'b1;
               walk_in             = '0;
               cur_in              = root_ff;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_ff       <= '0;
         count_ff      <= '0;
         finished_ff   <= 1'b0;
         total_ff      <= '0;
         pending_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         count_ff      <= count_in;
         finished_ff   <= finished_in;
         total_ff      <= total_in;
         pending_ff    <= pending_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      bit_ff      <= bit_in;
      child_ff    <= child_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions.
   `HTD_ASSERT_SAME(a_read_only_walking, ram_re, !ram_we && (state_ff == ST_WALK), "table read outside walk")
   `HTD_ASSERT_SAME(a_emit_slot_free, emit && rsp_valid_ff, rsp_ready, "result overwrote a waiting result")
   `HTD_ASSERT_NEXT(a_decode_starts, req_xfer && (req_data.cmd == CMD_DECODE) && !finished_ff && (count_ff < total_ff), state_ff == ST_WALK, "decode byte did not start a walk")
   `HTD_ASSERT_SAME(a_status_on_last, state_ff == ST_STATUS, last_ff && !finished_ff, "status without a short last byte")
   `HTD_ASSERT_SAME(a_held_empty_idle, state_ff == ST_IDLE, !held_valid_ff, "symbol left held while idle")

endmodule
